// ===== rtl/multicycle_cpu_control_fsm_top_macros.svh =====
// ----------------------------------------------------------------------------
// control fsm assertion macros
// clocked property wrappers used by the control fsm top rtl
// ----------------------------------------------------------------------------
`ifndef MULTICYCLE_CPU_CONTROL_FSM_TOP_MACROS_SVH
`define MULTICYCLE_CPU_CONTROL_FSM_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define MCF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MCF_ASSERT_IMPL(lbl, ante, cons, msg)
`define MCF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcf_pkg
// types and codes shared by the control fsm rtl
// ----------------------------------------------------------------------------
`default_nettype none

package mcf_pkg;

    // micro-state codes
    localparam logic [3:0] S_FETCH    = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_MEM_ADR  = 4'd2;
    localparam logic [3:0] S_MEM_RD   = 4'd3;
    localparam logic [3:0] S_MEM_WB   = 4'd4;
    localparam logic [3:0] S_MEM_WR   = 4'd5;
    localparam logic [3:0] S_ADDI_WB  = 4'd6;
    localparam logic [3:0] S_R_EXEC   = 4'd7;
    localparam logic [3:0] S_R_WB     = 4'd8;
    localparam logic [3:0] S_BRANCH   = 4'd9;
    localparam logic [3:0] S_JUMP     = 4'd10;

    // opcodes
    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_J     = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    // alu codes
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd2;

    typedef struct packed {
        logic [3:0] opcode;
        logic [2:0] funct;
    } t_mcf_in;

    typedef struct packed {
        logic       pc_write;
        logic       i_or_d;
        logic       mem_write;
        logic       ir_write;
        logic       mem_to_reg;
        logic       reg_write;
        logic       alu_src_a;
        logic [1:0] alu_src_b;
        logic [2:0] alu_op;
        logic [1:0] pc_src;
        logic       reg_dst;
        logic       branch;
    } t_mcf_out;

endpackage

`default_nettype wire

// ===== rtl/multicycle_cpu_control_fsm_top.sv =====
// ----------------------------------------------------------------------------
// multicycle_cpu_control_fsm_top
// control unit of a small multicycle cpu
//
// each input item is one cpu control step carrying opcode and funct. the
// block answers with one item of control signals decoded from the current
// micro-state and funct, then advances the micro-state with the item's opcode.
// input channel: i_in_valid / o_in_stall / i_in_item. output channel:
// o_out_valid / i_out_stall / o_out_item.
// latency: the result item is valid in the cycle after the input item is
// accepted, held in a single output register.
// throughput: one item per cycle unless the receiver stalls, set by the output
// register; the state register updates in the same cycle the item is accepted.
// when the receiver stalls with a result waiting, o_in_stall rises and the
// waiting result holds; the next item is taken in the cycle the result goes.
// reset: synchronous, active low; the micro-state returns to fetch and the
// output register empties.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multicycle_cpu_control_fsm_top_macros.svh"

module multicycle_cpu_control_fsm_top
    import mcf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_mcf_in i_in_item,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_mcf_out     o_out_item
);

    typedef enum logic [3:0] {
        ST_FETCH   = S_FETCH,
        ST_DECODE  = S_DECODE,
        ST_MEM_ADR = S_MEM_ADR,
        ST_MEM_RD  = S_MEM_RD,
        ST_MEM_WB  = S_MEM_WB,
        ST_MEM_WR  = S_MEM_WR,
        ST_ADDI_WB = S_ADDI_WB,
        ST_R_EXEC  = S_R_EXEC,
        ST_R_WB    = S_R_WB,
        ST_BRANCH  = S_BRANCH,
        ST_JUMP    = S_JUMP
    } t_state;

    t_state   r_state;
    t_state   n_state;
    logic     r_out_valid;
    t_mcf_out r_out_item;
    t_mcf_out w_dec;
    logic     w_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    mcf_out_decode u_decode (
        .i_state (r_state),
        .i_funct (i_in_item.funct),
        .o_item  (w_dec)
    );

    always_comb begin
        case (r_state)
            ST_FETCH: n_state = ST_DECODE;
            ST_DECODE: begin
                case (i_in_item.opcode) inside
                    OP_RTYPE:               n_state = ST_R_EXEC;
                    OP_ADDI, OP_LW, OP_SW:  n_state = ST_MEM_ADR;
                    OP_BEQ:                 n_state = ST_BRANCH;
                    OP_J:                   n_state = ST_JUMP;
                    default:                n_state = ST_FETCH;
                endcase
            end
            ST_MEM_ADR: begin
                case (i_in_item.opcode)
                    OP_ADDI: n_state = ST_ADDI_WB;
                    OP_LW:   n_state = ST_MEM_RD;
                    OP_SW:   n_state = ST_MEM_WR;
                    default: n_state = ST_FETCH;
                endcase
            end
            ST_MEM_RD: n_state = ST_MEM_WB;
            ST_R_EXEC: n_state = ST_R_WB;
            default:   n_state = ST_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_out_valid <= 1'b0;
            r_out_item  <= '0;
        end else begin
            if (w_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
                r_out_item  <= w_dec;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `MCF_ASSERT_NEXT(a_fetch_to_decode, w_accept && (r_state == ST_FETCH),
        r_state == ST_DECODE && o_out_item.ir_write, "fetch did not go to decode")
    `MCF_ASSERT_NEXT(a_state_holds, !w_accept, $stable(r_state),
        "state moved without an item")
    `MCF_ASSERT_NEXT(a_accept_gives_result, w_accept, r_out_valid,
        "accepted item produced no result")
    `MCF_ASSERT_IMPL(a_stall_when_full, r_out_valid && i_out_stall, !w_accept,
        "item accepted while result blocked")

endmodule

`default_nettype wire

// ===== rtl/mcf_out_decode.sv =====
// ----------------------------------------------------------------------------
// mcf_out_decode
// control signal decode from the current micro-state and funct
// ----------------------------------------------------------------------------
`default_nettype none

module mcf_out_decode
    import mcf_pkg::*;
(
    input  wire logic [3:0] i_state,
    input  wire logic [2:0] i_funct,
    output t_mcf_out        o_item
);

    logic [3:0] s;
    logic       w_hi;

    assign s = i_state;

    always_comb begin
        o_item.pc_write   = (s == S_FETCH) || (s == S_JUMP);
        o_item.i_or_d     = ((s & 4'd14) == 4'd4) || (s == S_MEM_RD);
        o_item.mem_write  = (s == S_MEM_WR);
        o_item.ir_write   = (s == S_FETCH);
        o_item.mem_to_reg = (s == S_MEM_WB);
        o_item.reg_write  = ((s & 4'd13) == 4'd4) || (s == S_R_WB);
        o_item.alu_src_a  = ((s & 4'd10) == 4'd2) || ((s & 4'd10) == 4'd8) || s[2];
        w_hi              = ((s & 4'd6) == 4'd4) || ((s & 4'd13) == 4'd1)
                            || ((s & 4'd11) == 4'd2);
        o_item.alu_src_b  = {w_hi, (s == S_FETCH)};
        if (s < S_R_EXEC) begin
            o_item.alu_op = ALU_ADD;
        end else if ((s == S_R_EXEC) || (s == S_R_WB) || (s == S_JUMP)) begin
            o_item.alu_op = i_funct;
        end else begin
            o_item.alu_op = ALU_SUB;
        end
        o_item.pc_src     = {(s == S_JUMP), (s == S_BRANCH)};
        o_item.reg_dst    = ((s & 4'd14) == 4'd0) || (s == S_R_EXEC) || (s == S_R_WB);
        o_item.branch     = (s == S_BRANCH);
    end

endmodule

`default_nettype wire

// ===== verif/multicycle_cpu_control_fsm_top_test.sv =====
// ----------------------------------------------------------------------------
// multicycle_cpu_control_fsm_top_test
// self-checking bench for the multicycle cpu control unit
//
// a scoreboard class keeps its own micro-state, decodes the control signals
// expected for every accepted step item and checks each result item in
// order. stimulus is a short set of hand-picked instructions followed by
// random instruction streams with some corrupted opcodes. both channels
// idle at random in the first two of three phases; the third runs without idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multicycle_cpu_control_fsm_top_test;
    import mcf_pkg::*;

    class mcf_ctrl_board;
        logic [3:0]  micro_state;
        t_mcf_out    pending_ctrl[$];
        int unsigned mismatches;

        function new();
            micro_state = S_FETCH;
            mismatches  = 0;
        endfunction

        function t_mcf_out decode_controls(logic [3:0] s, logic [2:0] fn);
            t_mcf_out c;
            logic     hi;
            c = '0;
            c.pc_write   = (s == S_FETCH) || (s == S_JUMP);
            c.i_or_d     = ((s & 4'b1110) == 4'b0100) || (s == S_MEM_RD);
            c.mem_write  = (s == S_MEM_WR);
            c.ir_write   = (s == S_FETCH);
            c.mem_to_reg = (s == S_MEM_WB);
            c.reg_write  = ((s & 4'b1101) == 4'b0100) || (s == S_R_WB);
            c.alu_src_a  = ((s & 4'b1010) == 4'b0010) || ((s & 4'b1010) == 4'b1000) || s[2];
            hi = ((s & 4'b0110) == 4'b0100) || ((s & 4'b1101) == 4'b0001)
                || ((s & 4'b1011) == 4'b0010);
            c.alu_src_b  = {hi, (s == S_FETCH)};
            if (s < S_R_EXEC)
                c.alu_op = ALU_ADD;
            else if ((s == S_R_EXEC) || (s == S_R_WB) || (s == S_JUMP))
                c.alu_op = fn;
            else
                c.alu_op = ALU_SUB;
            c.pc_src     = {(s == S_JUMP), (s == S_BRANCH)};
            c.reg_dst    = ((s & 4'b1110) == 4'b0000) || (s == S_R_EXEC) || (s == S_R_WB);
            c.branch     = (s == S_BRANCH);
            return c;
        endfunction

        function logic [3:0] next_micro_state(logic [3:0] s, logic [3:0] op);
            case (s)
                S_FETCH: return S_DECODE;
                S_DECODE: begin
                    if (op == OP_RTYPE) return S_R_EXEC;
                    if ((op == OP_ADDI) || (op == OP_LW) || (op == OP_SW)) return S_MEM_ADR;
                    if (op == OP_BEQ) return S_BRANCH;
                    if (op == OP_J) return S_JUMP;
                    return S_FETCH;
                end
                S_MEM_ADR: begin
                    if (op == OP_ADDI) return S_ADDI_WB;
                    if (op == OP_LW) return S_MEM_RD;
                    if (op == OP_SW) return S_MEM_WR;
                    return S_FETCH;
                end
                S_MEM_RD: return S_MEM_WB;
                S_R_EXEC: return S_R_WB;
                default: return S_FETCH;
            endcase
        endfunction

        function void note_step(t_mcf_in it);
            pending_ctrl.push_back(decode_controls(micro_state, it.funct));
            micro_state = next_micro_state(micro_state, it.opcode);
        endfunction

        function void report(string what, t_mcf_out exp_c, t_mcf_out got_c);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s expected %b actual %b", what, exp_c, got_c);
        endfunction

        function void check_controls(t_mcf_out got_c);
            t_mcf_out exp_c;
            logic     bad;
            if (pending_ctrl.size() == 0) begin
                report("unexpected result item", '0, got_c);
                return;
            end
            exp_c = pending_ctrl.pop_front();
            bad = (got_c.pc_write   !== exp_c.pc_write)
               || (got_c.i_or_d     !== exp_c.i_or_d)
               || (got_c.mem_write  !== exp_c.mem_write)
               || (got_c.ir_write   !== exp_c.ir_write)
               || (got_c.mem_to_reg !== exp_c.mem_to_reg)
               || (got_c.reg_write  !== exp_c.reg_write)
               || (got_c.alu_src_a  !== exp_c.alu_src_a)
               || (got_c.alu_src_b  !== exp_c.alu_src_b)
               || (got_c.alu_op     !== exp_c.alu_op)
               || (got_c.pc_src     !== exp_c.pc_src)
               || (got_c.reg_dst    !== exp_c.reg_dst)
               || (got_c.branch     !== exp_c.branch);
            if (bad)
                report("control item", exp_c, got_c);
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_out_stall = 1'b0;
    t_mcf_in     i_in_item   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_mcf_out    o_out_item;

    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 60;
    int unsigned item_count    = 0;

    mcf_ctrl_board board = new();

    multicycle_cpu_control_fsm_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("multicycle_cpu_control_fsm_top regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                board.check_controls(o_out_item);
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_item(logic [3:0] op, logic [2:0] fn);
        t_mcf_in it;
        it.opcode = op;
        it.funct  = fn;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        board.note_step(it);
        item_count++;
    endtask

    // one instruction from fetch back to fetch with a fixed opcode
    task automatic run_instr(logic [3:0] op, logic [2:0] fn);
        send_item(op, fn);
        while (board.micro_state != S_FETCH)
            send_item(op, fn);
    endtask

    task automatic run_random_instr();
        logic [3:0] op;
        logic [3:0] known_ops[6];
        known_ops = '{OP_RTYPE, OP_J, OP_ADDI, OP_BEQ, OP_LW, OP_SW};
        if ($urandom_range(99) < 80)
            op = known_ops[$urandom_range(5)];
        else
            op = 4'($urandom_range(15));
        send_item(op, 3'($urandom_range(7)));
        while (board.micro_state != S_FETCH) begin
            // corrupted opcode mid-instruction
            if ($urandom_range(99) < 8)
                op = 4'($urandom_range(15));
            send_item(op, 3'($urandom_range(7)));
        end
    endtask

    task automatic run_phase(int unsigned n);
        int unsigned target;
        target = item_count + n;
        while (item_count < target)
            run_random_instr();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_instr(OP_RTYPE, 3'd7);
        run_instr(OP_J, 3'd0);
        run_instr(OP_ADDI, 3'd5);
        run_instr(OP_BEQ, 3'd3);
        run_instr(OP_LW, 3'd7);
        run_instr(OP_SW, 3'd0);
        // unknown opcode falls back to fetch from decode
        run_instr(4'd13, 3'd6);
        // load decoded, then a foreign opcode at address computation
        send_item(OP_LW, 3'd1);
        send_item(OP_LW, 3'd2);
        send_item(4'd9, 3'd4);

        run_phase(360);
        send_idle_pct = 60;
        recv_idle_pct = 15;
        run_phase(360);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(360);
        i_in_valid <= 1'b0;

        while (board.pending_ctrl.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending_ctrl.size() == 0)
            $display("multicycle_cpu_control_fsm_top regression: pass");
        else
            $display("multicycle_cpu_control_fsm_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mcf_pkg.sv
rtl/mcf_out_decode.sv
rtl/multicycle_cpu_control_fsm_top.sv
verif/multicycle_cpu_control_fsm_top_test.sv
